// File: rtl/tlsrs_pkg.sv
`default_nettype none

package tlsrs_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int WIN_LEN = 5;

    localparam logic [7:0]  TYPE_FIRST   = 8'h14;
    localparam logic [7:0]  TYPE_LAST    = 8'h17;
    localparam logic [7:0]  TYPE_HSHAKE  = 8'h16;
    localparam logic [15:0] VER_MIN      = 16'h0300;
    localparam logic [15:0] VER_MAX      = 16'h0304;
    localparam logic [7:0]  MSG_CLIENT   = 8'h01;
    localparam logic [7:0]  MSG_SERVER   = 8'h02;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_CLIENT = 2'd1;
    localparam logic [1:0] CLASS_SERVER = 2'd2;
    localparam logic [1:0] CLASS_OTHER  = 2'd3;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  record_type;
        logic [15:0] record_version;
        logic [15:0] record_length;
        logic [1:0]  hello_class;
        logic [31:0] packet_total;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic    wr0;
        logic    wr1;
        result_t res0;
        result_t res1;
    } push_t;

    function automatic logic hdr_ok(input logic [7:0] t, input logic [15:0] v);
        return (t >= TYPE_FIRST) && (t <= TYPE_LAST) && (v >= VER_MIN) && (v <= VER_MAX);
    endfunction

endpackage

`default_nettype wire

// File: rtl/tlsrs_if.sv
`default_nettype none

interface tlsrs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_end;

    modport source (output valid, output data_byte, output packet_end, input ready);
    modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

interface tlsrs_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  record_type;
    logic [15:0] record_version;
    logic [15:0] record_length;
    logic [1:0]  hello_class;
    logic [31:0] packet_total;
    logic        last_result;

    modport source (output valid, output item_kind, output record_type,
                    output record_version, output record_length, output hello_class,
                    output packet_total, output last_result, input ready);
    modport sink (input valid, input item_kind, input record_type,
                  input record_version, input record_length, input hello_class,
                  input packet_total, input last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/tlsrs_scan.sv
`default_nettype none

module tlsrs_scan
    import tlsrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       packet_end,
    output push_t           push
);

    logic [7:0]  win_reg [0:WIN_LEN-1];
    logic [7:0]  win_next [0:WIN_LEN-1];
    logic [2:0]  fill_reg, fill_next;
    logic [15:0] skip_reg, skip_next;
    logic [31:0] total_reg, total_next;

    logic [7:0]  w6 [0:WIN_LEN];
    logic        take;
    logic [2:0]  fill1;
    logic        full6;
    logic        judge0;
    logic        ok0;
    logic        ok1;
    logic        found;
    logic [7:0]  rec_type;
    logic [15:0] rec_ver;
    logic [15:0] rec_len;
    logic [1:0]  rec_class;
    logic [32:0] sum33;
    logic [31:0] total_sat;
    result_t     rec;
    result_t     summ;

    always_comb
    begin
        take = (skip_reg == 16'd0);
        fill1 = fill_reg + {2'b00, take};
        for (int i = 0; i < WIN_LEN; i++)
        begin
            if (3'(i) < fill_reg)
                w6[i] = win_reg[i];
            else if ((3'(i) == fill_reg) && take)
                w6[i] = data_byte;
            else
                w6[i] = 8'h00;
        end
        w6[WIN_LEN] = ((fill_reg == 3'(WIN_LEN)) && take) ? data_byte : 8'h00;

        full6 = (fill1 == 3'(WIN_LEN + 1));
        judge0 = (fill1 >= 3'(WIN_LEN)) && (packet_end || full6);
        ok0 = judge0 && hdr_ok(w6[0], {w6[1], w6[2]});
        ok1 = packet_end && full6 && !ok0 && hdr_ok(w6[1], {w6[2], w6[3]});
        found = ok0 || ok1;

        // second position at packet end never sees its hello byte
        if (ok0)
        begin
            rec_type = w6[0];
            rec_ver = {w6[1], w6[2]};
            rec_len = {w6[3], w6[4]};
            if (w6[0] != TYPE_HSHAKE)
                rec_class = CLASS_NONE;
            else if (full6 && (w6[5] == MSG_CLIENT))
                rec_class = CLASS_CLIENT;
            else if (full6 && (w6[5] == MSG_SERVER))
                rec_class = CLASS_SERVER;
            else
                rec_class = CLASS_OTHER;
        end
        else
        begin
            rec_type = w6[1];
            rec_ver = {w6[2], w6[3]};
            rec_len = {w6[4], w6[5]};
            rec_class = (w6[1] == TYPE_HSHAKE) ? CLASS_OTHER : CLASS_NONE;
        end

        sum33 = {1'b0, total_reg} + {17'd0, rec_len};
        total_sat = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];

        rec.item_kind = KIND_RECORD;
        rec.record_type = rec_type;
        rec.record_version = rec_ver;
        rec.record_length = rec_len;
        rec.hello_class = rec_class;
        rec.packet_total = total_sat;
        rec.last_result = !packet_end;

        summ.item_kind = KIND_SUMMARY;
        summ.record_type = 8'h00;
        summ.record_version = 16'h0000;
        summ.record_length = 16'h0000;
        summ.hello_class = CLASS_NONE;
        summ.packet_total = found ? total_sat : total_reg;
        summ.last_result = 1'b1;

        push.wr0 = accept && (found || packet_end);
        push.res0 = found ? rec : summ;
        push.wr1 = accept && found && packet_end;
        push.res1 = summ;

        for (int i = 0; i < WIN_LEN; i++)
            win_next[i] = w6[i];
        fill_next = fill1;
        skip_next = take ? skip_reg : skip_reg - 16'd1;
        total_next = total_reg;

        if (packet_end)
        begin
            fill_next = 3'd0;
            skip_next = 16'd0;
            total_next = 32'd0;
        end
        else if (ok0)
        begin
            total_next = total_sat;
            if (rec_len != 16'd0)
            begin
                fill_next = 3'd0;
                skip_next = rec_len - 16'd1;
            end
            else
            begin
                fill_next = 3'd1;
                win_next[0] = w6[5];
            end
        end
        else if (full6)
        begin
            for (int i = 0; i < WIN_LEN; i++)
                win_next[i] = w6[i+1];
            fill_next = 3'(WIN_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
            skip_reg <= 16'd0;
            total_reg <= 32'd0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            skip_reg <= skip_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WIN_LEN; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tlsrs_out_fifo.sv
`default_nettype none

module tlsrs_out_fifo
    import tlsrs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       space_ok,
    output logic       res_valid,
    input  wire logic  res_ready,
    output result_t    res_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t       mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_inc;
    logic          pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        res_valid = (count_reg != '0);
        res_data = mem_reg[rd_ptr_reg];
        space_ok = (count_reg <= CW'(DEPTH - 2));
        pop = res_valid && res_ready;
        wr_ptr_inc = wrap_inc(wr_ptr_reg);

        wr_ptr_next = wr_ptr_reg;
        if (push.wr0 && push.wr1)
            wr_ptr_next = wrap_inc(wr_ptr_inc);
        else if (push.wr0)
            wr_ptr_next = wr_ptr_inc;

        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next = count_reg + CW'(push.wr0) + CW'(push.wr1) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.wr0)
            mem_reg[wr_ptr_reg] <= push.res0;
        if (push.wr1)
            mem_reg[wr_ptr_inc] <= push.res1;
    end

endmodule

`default_nettype wire

// File: rtl/tls_record_header_scanner_unit.sv
`default_nettype none

// Scans a TCP payload one byte per request for TLS record headers (type 0x14 to 0x17,
// version 0x300 to 0x304) and returns one request per record found, carrying its type,
// version, length, hello class and the saturating running length total, plus a summary
// request with the total at the last byte of each packet. A byte is taken every cycle
// while the result queue has room for two entries; a record shows up once the byte after
// its header is seen, or with its last header byte at packet end. The packet end byte
// yields up to two results (a record and the summary), which leave the queue in turn.
module tls_record_header_scanner_unit
    import tlsrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input wire logic   clk,
    input wire logic   rst_n,
    tlsrs_in_if.sink   bytes,
    tlsrs_out_if.source results
);

    logic    space_ok;
    logic    accept;
    push_t   push;
    result_t head;

    assign bytes.ready = space_ok;
    assign accept = bytes.valid && space_ok;

    tlsrs_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (bytes.data_byte),
        .packet_end (bytes.packet_end),
        .push       (push)
    );

    tlsrs_out_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .res_valid (results.valid),
        .res_ready (results.ready),
        .res_data  (head)
    );

    assign results.item_kind = head.item_kind;
    assign results.record_type = head.record_type;
    assign results.record_version = head.record_version;
    assign results.record_length = head.record_length;
    assign results.hello_class = head.hello_class;
    assign results.packet_total = head.packet_total;
    assign results.last_result = head.last_result;

endmodule

`default_nettype wire
